### rtl/pfbu_pkg.sv
// ----------------------------------------------------------------------------
// pfbu_pkg - shared definitions for the up-channelizer
// Field widths, command codes, default sizes and the twiddle table.
// ----------------------------------------------------------------------------
package pfbu_pkg;

	localparam int TAPS_DEF   = 4;
	localparam int UPCHAN_DEF = 16;

	localparam int CMD_W  = 2;
	localparam int SMP_W  = 4;
	localparam int IDX_W  = 6;
	localparam int COEF_W = 16;
	localparam int OUT_W  = 4;
	localparam int CH_W   = 4;

	localparam int ROM_W     = 5;
	localparam int SIN_OFS   = 24;
	localparam int RND_POS   = 35;
	localparam int FRAC_BITS = 36;
	localparam int SAT_MAX   = 7;

	localparam logic signed [COEF_W-1:0] GAIN_ONE = 16'sd256;

	typedef enum logic [CMD_W-1:0] {
		CMD_SAMPLE = 2'd0,
		CMD_WEIGHT = 2'd1,
		CMD_GAIN   = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	function automatic logic signed [COEF_W-1:0] cos_rom(input logic [ROM_W-1:0] j);
		logic signed [COEF_W-1:0] v;
		case (j)
			5'd0:  v = 16'sd16384;
			5'd1:  v = 16'sd16069;
			5'd2:  v = 16'sd15137;
			5'd3:  v = 16'sd13623;
			5'd4:  v = 16'sd11585;
			5'd5:  v = 16'sd9102;
			5'd6:  v = 16'sd6270;
			5'd7:  v = 16'sd3196;
			5'd8:  v = 16'sd0;
			5'd9:  v = -16'sd3196;
			5'd10: v = -16'sd6270;
			5'd11: v = -16'sd9102;
			5'd12: v = -16'sd11585;
			5'd13: v = -16'sd13623;
			5'd14: v = -16'sd15137;
			5'd15: v = -16'sd16069;
			5'd16: v = -16'sd16384;
			5'd17: v = -16'sd16069;
			5'd18: v = -16'sd15137;
			5'd19: v = -16'sd13623;
			5'd20: v = -16'sd11585;
			5'd21: v = -16'sd9102;
			5'd22: v = -16'sd6270;
			5'd23: v = -16'sd3196;
			5'd24: v = 16'sd0;
			5'd25: v = 16'sd3196;
			5'd26: v = 16'sd6270;
			5'd27: v = 16'sd9102;
			5'd28: v = 16'sd11585;
			5'd29: v = 16'sd13623;
			5'd30: v = 16'sd15137;
			default: v = 16'sd16069;
		endcase
		return v;
	endfunction

endpackage

### rtl/pfbu_in_if.sv
// ----------------------------------------------------------------------------
// pfbu_in_if - input channel
// Valid/ready channel carrying commands, samples and table writes.
// ----------------------------------------------------------------------------
interface pfbu_in_if;
	logic                                   valid;
	logic                                   ready;
	logic [pfbu_pkg::CMD_W-1:0]             command;
	logic signed [pfbu_pkg::SMP_W-1:0]      sample_real;
	logic signed [pfbu_pkg::SMP_W-1:0]      sample_imag;
	logic [pfbu_pkg::IDX_W-1:0]             table_index;
	logic signed [pfbu_pkg::COEF_W-1:0]     coeff_value;

	modport source (output valid, command, sample_real, sample_imag, table_index,
		coeff_value, input ready);
	modport sink (input valid, command, sample_real, sample_imag, table_index,
		coeff_value, output ready);
endinterface

### rtl/pfbu_out_if.sv
// ----------------------------------------------------------------------------
// pfbu_out_if - result channel
// Valid/ready channel carrying one channel output per beat.
// ----------------------------------------------------------------------------
interface pfbu_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [pfbu_pkg::OUT_W-1:0]  out_real;
	logic signed [pfbu_pkg::OUT_W-1:0]  out_imag;
	logic [pfbu_pkg::CH_W-1:0]          channel;
	logic                               last;

	modport source (output valid, out_real, out_imag, channel, last, input ready);
	modport sink (input valid, out_real, out_imag, channel, last, output ready);
endinterface

### rtl/pfb_upchannelizer.sv
// ----------------------------------------------------------------------------
// pfb_upchannelizer - polyphase filter bank up-channelizer
// Each channel output: one MAC pass over the window (one tap a cycle through the
// delay-line and weight memory ports), then the memory read and product pipeline
// registers, a gain step (ST_GAIN) and a rounding step (ST_EMIT), which waits
// for a free output slot.
// Inputs are taken one per cycle while no block is being computed.
// After reset the weight memory is swept to zero (ST_CLEAR) and no input is taken.
// ----------------------------------------------------------------------------
module pfb_upchannelizer #(
	parameter int TAPS          = pfbu_pkg::TAPS_DEF,
	parameter int UPCHAN_FACTOR = pfbu_pkg::UPCHAN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	pfbu_in_if.sink    samples,
	pfbu_out_if.source results
);

	localparam int WIN_LEN = TAPS * UPCHAN_FACTOR;
	localparam int WA      = $clog2(WIN_LEN);
	localparam int UW      = $clog2(UPCHAN_FACTOR);
	localparam int KW      = $clog2(2 * UPCHAN_FACTOR);
	localparam int FW      = $clog2(WIN_LEN + 1);
	localparam int CW      = pfbu_pkg::COEF_W;
	localparam int PROD_W  = 2 * CW;
	localparam int TERM_W  = PROD_W + 2;
	localparam int ACC_W   = TERM_W + WA + 1;
	localparam int LO_W    = 24;
	localparam int HI_W    = ACC_W - LO_W;
	localparam int PW      = ACC_W + CW + 1;
	localparam int QW      = PW - pfbu_pkg::FRAC_BITS;
	localparam int SW      = pfbu_pkg::SMP_W;
	localparam int OW      = pfbu_pkg::OUT_W;

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_MAC   = 5'b00100,
		ST_GAIN  = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

	state_t state_q;

	logic [2*SW-1:0]       dl_mem [WIN_LEN];
	logic signed [CW-1:0]  w_mem  [WIN_LEN];
	logic signed [CW-1:0]  g_mem  [UPCHAN_FACTOR];
	logic [UPCHAN_FACTOR-1:0] g_vld_q;

	logic [pfbu_pkg::ROM_W-1:0] jtab [2*UPCHAN_FACTOR];
	for (genvar g = 0; g < 2 * UPCHAN_FACTOR; g++) begin : g_jtab
		assign jtab[g] = pfbu_pkg::ROM_W'((g * 16) / UPCHAN_FACTOR);
	end

	logic [WA-1:0] wr_ptr_q, wr_ptr_nx, rd_ptr_q, clr_q, s_q;
	logic [FW-1:0] fill_q;
	logic [UW-1:0] phase_q, u_q;
	logic [KW-1:0] k_q;
	logic          issue_q;

	pfbu_pkg::cmd_t cmd;
	logic in_fire, smp_wr, w_wr, g_wr, emit_go;

	assign samples.ready = (state_q == ST_IDLE);
	assign in_fire = samples.valid & samples.ready;
	assign cmd     = pfbu_pkg::cmd_t'(samples.command);
	assign smp_wr  = in_fire && (cmd == pfbu_pkg::CMD_SAMPLE);
	assign w_wr    = in_fire && (cmd == pfbu_pkg::CMD_WEIGHT)
		&& (32'(samples.table_index) < 32'(WIN_LEN));
	assign g_wr    = in_fire && (cmd == pfbu_pkg::CMD_GAIN)
		&& (32'(samples.table_index) < 32'(UPCHAN_FACTOR));
	assign wr_ptr_nx = (wr_ptr_q == WA'(WIN_LEN - 1)) ? '0 : wr_ptr_q + 1'b1;
	assign emit_go = smp_wr && ((fill_q == FW'(WIN_LEN - 1))
		|| ((fill_q == FW'(WIN_LEN)) && (phase_q == UW'(UPCHAN_FACTOR - 1))));

	// twiddle step for the current channel and twiddle index for the next tap
	logic [KW:0] m_raw, m_red, k_sum;
	logic [KW-1:0] m, k_nx;
	always_comb begin
		m_raw = (KW+1)'(3 * UPCHAN_FACTOR - 1) - (KW+1)'({u_q, 1'b0});
		m_red = (m_raw >= (KW+1)'(2 * UPCHAN_FACTOR))
			? m_raw - (KW+1)'(2 * UPCHAN_FACTOR) : m_raw;
		m     = m_red[KW-1:0];
		k_sum = (KW+1)'(k_q) + (KW+1)'(m);
		k_nx  = (k_sum >= (KW+1)'(2 * UPCHAN_FACTOR))
			? KW'(k_sum - (KW+1)'(2 * UPCHAN_FACTOR)) : k_sum[KW-1:0];
	end

	// memories
	logic            w_we;
	logic [WA-1:0]   w_wa;
	logic signed [CW-1:0] w_wd;
	assign w_we = (state_q == ST_CLEAR) || w_wr;
	assign w_wa = (state_q == ST_CLEAR) ? clr_q : WA'(samples.table_index);
	assign w_wd = (state_q == ST_CLEAR) ? '0 : samples.coeff_value;

	logic signed [CW-1:0] w_s1, cos_s1, sin_s1, g_rd_q;
	logic [2*SW-1:0]      dl_s1;
	logic [pfbu_pkg::ROM_W-1:0] j_cur;
	assign j_cur = jtab[k_q];

	always_ff @(posedge clk) begin
		if (w_we) w_mem[w_wa] <= w_wd;
		if (smp_wr) dl_mem[wr_ptr_q] <= {samples.sample_real, samples.sample_imag};
		if (g_wr) g_mem[UW'(samples.table_index)] <= samples.coeff_value;
		w_s1   <= w_mem[s_q];
		dl_s1  <= dl_mem[rd_ptr_q];
		g_rd_q <= g_mem[u_q];
		cos_s1 <= pfbu_pkg::cos_rom(j_cur);
		sin_s1 <= pfbu_pkg::cos_rom(j_cur + pfbu_pkg::ROM_W'(pfbu_pkg::SIN_OFS));
	end

	// product pipeline
	logic signed [PROD_W-1:0] wc_s2, ws_s2;
	logic signed [SW-1:0]     a_s2, b_s2;
	always_ff @(posedge clk) begin
		wc_s2 <= w_s1 * cos_s1;
		ws_s2 <= w_s1 * sin_s1;
		a_s2  <= dl_s1[2*SW-1:SW];
		b_s2  <= dl_s1[SW-1:0];
	end

	logic signed [TERM_W-1:0] wc_x, ws_x, t_re, t_im;
	assign wc_x = TERM_W'(wc_s2);
	assign ws_x = TERM_W'(ws_s2);
	assign t_re = wc_x * a_s2 - ws_x * b_s2;
	assign t_im = wc_x * b_s2 + ws_x * a_s2;

	logic signed [ACC_W-1:0] acc_re_q, acc_im_q;
	logic vld_s1, end_s1, vld_s2, end_s2;

	// gain and rounding
	logic signed [CW-1:0] g_sel;
	assign g_sel = g_vld_q[u_q] ? g_rd_q : pfbu_pkg::GAIN_ONE;

	logic signed [LO_W+CW:0]   plo_re_q, plo_im_q;
	logic signed [HI_W+CW-1:0] phi_re_q, phi_im_q;
	logic signed [PW-1:0]      tot_re, tot_im;
	logic signed [QW-1:0]      q_re, q_im;
	logic signed [OW-1:0]      o_re, o_im;

	always_comb begin
		tot_re = (PW'(phi_re_q) <<< LO_W) + PW'(plo_re_q) + (PW'(1) <<< pfbu_pkg::RND_POS);
		tot_im = (PW'(phi_im_q) <<< LO_W) + PW'(plo_im_q) + (PW'(1) <<< pfbu_pkg::RND_POS);
		q_re   = QW'(tot_re >>> pfbu_pkg::FRAC_BITS);
		q_im   = QW'(tot_im >>> pfbu_pkg::FRAC_BITS);
		if (q_re > QW'(pfbu_pkg::SAT_MAX)) o_re = OW'(pfbu_pkg::SAT_MAX);
		else if (q_re < -QW'(pfbu_pkg::SAT_MAX)) o_re = -OW'(pfbu_pkg::SAT_MAX);
		else o_re = OW'(q_re);
		if (q_im > QW'(pfbu_pkg::SAT_MAX)) o_im = OW'(pfbu_pkg::SAT_MAX);
		else if (q_im < -QW'(pfbu_pkg::SAT_MAX)) o_im = -OW'(pfbu_pkg::SAT_MAX);
		else o_im = OW'(q_im);
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_GAIN) begin
			plo_re_q <= $signed({1'b0, acc_re_q[LO_W-1:0]}) * g_sel;
			plo_im_q <= $signed({1'b0, acc_im_q[LO_W-1:0]}) * g_sel;
			phi_re_q <= $signed(acc_re_q[ACC_W-1:LO_W]) * g_sel;
			phi_im_q <= $signed(acc_im_q[ACC_W-1:LO_W]) * g_sel;
		end
	end

	logic out_slot;
	assign out_slot = !results.valid || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
			phase_q  <= '0;
			u_q      <= '0;
			s_q      <= '0;
			k_q      <= '0;
			issue_q  <= 1'b0;
			vld_s1   <= 1'b0;
			end_s1   <= 1'b0;
			vld_s2   <= 1'b0;
			end_s2   <= 1'b0;
			g_vld_q  <= '0;
			acc_re_q <= '0;
			acc_im_q <= '0;
			results.valid <= 1'b0;
		end else begin
			vld_s1 <= (state_q == ST_MAC) && issue_q;
			end_s1 <= (state_q == ST_MAC) && issue_q && (s_q == WA'(WIN_LEN - 1));
			vld_s2 <= vld_s1;
			end_s2 <= end_s1;
			if (results.valid && results.ready && (state_q != ST_EMIT))
				results.valid <= 1'b0;
			if (g_wr) g_vld_q[UW'(samples.table_index)] <= 1'b1;
			if (vld_s2) begin
				acc_re_q <= acc_re_q + ACC_W'(t_re);
				acc_im_q <= acc_im_q + ACC_W'(t_im);
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == WA'(WIN_LEN - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (smp_wr) begin
						wr_ptr_q <= wr_ptr_nx;
						if (fill_q != FW'(WIN_LEN)) begin
							fill_q  <= fill_q + 1'b1;
							phase_q <= '0;
						end else begin
							phase_q <= (phase_q == UW'(UPCHAN_FACTOR - 1))
								? '0 : phase_q + 1'b1;
						end
					end
					if (emit_go) begin
						state_q  <= ST_MAC;
						u_q      <= '0;
						s_q      <= '0;
						k_q      <= '0;
						rd_ptr_q <= wr_ptr_nx;
						issue_q  <= 1'b1;
						acc_re_q <= '0;
						acc_im_q <= '0;
					end
				end
				ST_MAC: begin
					if (issue_q) begin
						s_q      <= s_q + 1'b1;
						k_q      <= k_nx;
						rd_ptr_q <= (rd_ptr_q == WA'(WIN_LEN - 1)) ? '0 : rd_ptr_q + 1'b1;
						if (s_q == WA'(WIN_LEN - 1)) issue_q <= 1'b0;
					end
					if (vld_s2 && end_s2) state_q <= ST_GAIN;
				end
				ST_GAIN: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_slot) begin
						results.valid    <= 1'b1;
						results.out_real <= o_re;
						results.out_imag <= o_im;
						results.channel  <= pfbu_pkg::CH_W'(u_q);
						results.last     <= (u_q == UW'(UPCHAN_FACTOR - 1));
						if (u_q == UW'(UPCHAN_FACTOR - 1)) begin
							state_q <= ST_IDLE;
						end else begin
							state_q  <= ST_MAC;
							u_q      <= u_q + 1'b1;
							s_q      <= '0;
							k_q      <= '0;
							rd_ptr_q <= wr_ptr_q;
							issue_q  <= 1'b1;
							acc_re_q <= '0;
							acc_im_q <= '0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### rtl/pfbu_chk.sv
// ----------------------------------------------------------------------------
// pfbu_chk - port checker for the up-channelizer
// Watches the result channel and input ready over time.
// ----------------------------------------------------------------------------
module pfbu_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [3:0] out_real,
	input logic [3:0] out_imag,
	input logic [3:0] channel,
	input logic       last
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_real)
			&& $stable(out_imag) && $stable(channel) && $stable(last))
		else $error("stalled result beat changed");

	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_real != 4'b1000) && (out_imag != 4'b1000))
		else $error("result outside saturation range");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> !in_ready)
		else $error("input taken while block in progress");

	a_next: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last |=> !out_valid || $past(in_ready) == 1'b0
			|| channel == 4'd0)
		else $error("block did not restart at channel zero");

endmodule

bind pfb_upchannelizer pfbu_chk u_pfbu_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (samples.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_real  (results.out_real),
	.out_imag  (results.out_imag),
	.channel   (results.channel),
	.last      (results.last)
);

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - up-channelizer testbench
// Drives samples, weight and gain writes over the input channel, predicts the
// sixteen channel outputs of every block in a scoreboard class and checks each
// result beat in order, with random idling on both sides and one long stall.
// ----------------------------------------------------------------------------
typedef struct packed {
	logic signed [pfbu_pkg::OUT_W-1:0] re;
	logic signed [pfbu_pkg::OUT_W-1:0] im;
	logic [pfbu_pkg::CH_W-1:0]         ch;
	logic                              last;
} chan_out_t;

class chan_scoreboard;
	localparam int WIN  = pfbu_pkg::TAPS_DEF * pfbu_pkg::UPCHAN_DEF;
	localparam int NCH  = pfbu_pkg::UPCHAN_DEF;
	localparam int twiddle[32] = '{
		16384, 16069, 15137, 13623, 11585, 9102, 6270, 3196,
		0, -3196, -6270, -9102, -11585, -13623, -15137, -16069,
		-16384, -16069, -15137, -13623, -11585, -9102, -6270, -3196,
		0, 3196, 6270, 9102, 11585, 13623, 15137, 16069
	};

	logic signed [pfbu_pkg::SMP_W-1:0]  win_re[WIN];
	logic signed [pfbu_pkg::SMP_W-1:0]  win_im[WIN];
	logic signed [pfbu_pkg::COEF_W-1:0] weights[WIN];
	logic signed [pfbu_pkg::COEF_W-1:0] gains[NCH];
	int                                 filled;
	int                                 phase;
	chan_out_t                          pending[$];
	int                                 mismatches;
	int                                 checked;
	int                                 blocks;

	function new();
		for (int i = 0; i < WIN; i++) begin
			weights[i] = '0;
			win_re[i] = '0;
			win_im[i] = '0;
		end
		for (int i = 0; i < NCH; i++) gains[i] = pfbu_pkg::GAIN_ONE;
		filled = 0;
		phase = 0;
		mismatches = 0;
		checked = 0;
		blocks = 0;
	endfunction

	function logic signed [pfbu_pkg::OUT_W-1:0] round_clip(longint v);
		longint q;
		q = (v + (longint'(1) << pfbu_pkg::RND_POS)) >>> pfbu_pkg::FRAC_BITS;
		if (q > pfbu_pkg::SAT_MAX) q = pfbu_pkg::SAT_MAX;
		if (q < -pfbu_pkg::SAT_MAX) q = -pfbu_pkg::SAT_MAX;
		return q[pfbu_pkg::OUT_W-1:0];
	endfunction

	function void predict_block();
		longint acc_re, acc_im, w, wc, ws, a, b, g;
		int m, k, j;
		chan_out_t e;
		blocks++;
		for (int u = 0; u < NCH; u++) begin
			acc_re = 0;
			acc_im = 0;
			m = (3 * NCH - 1 - 2 * u) % (2 * NCH);
			g = gains[u];
			for (int s = 0; s < WIN; s++) begin
				k = (s * m) % (2 * NCH);
				j = ((k * 16) / NCH) & 31;
				w = weights[s];
				wc = w * twiddle[j];
				ws = w * twiddle[(j + pfbu_pkg::SIN_OFS) & 31];
				a = win_re[s];
				b = win_im[s];
				acc_re += wc * a - ws * b;
				acc_im += wc * b + ws * a;
			end
			e.re = round_clip(acc_re * g);
			e.im = round_clip(acc_im * g);
			e.ch = u[pfbu_pkg::CH_W-1:0];
			e.last = (u == NCH - 1);
			pending.push_back(e);
		end
	endfunction

	function void note_input(pfbu_pkg::cmd_t cmd, logic signed [pfbu_pkg::SMP_W-1:0] re,
			logic signed [pfbu_pkg::SMP_W-1:0] im, logic [pfbu_pkg::IDX_W-1:0] idx,
			logic signed [pfbu_pkg::COEF_W-1:0] coef);
		case (cmd)
			pfbu_pkg::CMD_WEIGHT: if (idx < WIN) weights[idx] = coef;
			pfbu_pkg::CMD_GAIN: if (idx < NCH) gains[idx] = coef;
			pfbu_pkg::CMD_SAMPLE: begin
				for (int s = 0; s < WIN - 1; s++) begin
					win_re[s] = win_re[s+1];
					win_im[s] = win_im[s+1];
				end
				win_re[WIN-1] = re;
				win_im[WIN-1] = im;
				if (filled < WIN) begin
					filled++;
					if (filled == WIN) begin
						phase = 0;
						predict_block();
					end
				end else begin
					phase = (phase + 1) % NCH;
					if (phase == 0) predict_block();
				end
			end
			default: ;
		endcase
	endfunction

	function void check_result(chan_out_t got);
		chan_out_t e;
		checked++;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result beat: re=%0d im=%0d ch=%0d last=%0b",
					got.re, got.im, got.ch, got.last);
			return;
		end
		e = pending.pop_front();
		if (got.re !== e.re || got.im !== e.im || got.ch !== e.ch
				|| got.last !== e.last) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: exp re=%0d im=%0d ch=%0d last=%0b, %s%0d %s%0d %s%0d %s%0b",
					e.re, e.im, e.ch, e.last, "got re=", got.re, "im=", got.im,
					"ch=", got.ch, "last=", got.last);
		end
	endfunction
endclass

module tb_top;
	logic clk;
	logic arst_n;
	bit   idle_on;
	bit   hold_req;
	int   items_sent;

	pfbu_in_if  samples();
	pfbu_out_if results();

	chan_scoreboard sb;

	pfb_upchannelizer u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples.sink),
		.results (results.source)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("timeout");
		$display("[pfb_upchannelizer] ERROR");
		$finish;
	end

	task automatic send_item(pfbu_pkg::cmd_t cmd, logic signed [pfbu_pkg::SMP_W-1:0] re,
			logic signed [pfbu_pkg::SMP_W-1:0] im, logic [pfbu_pkg::IDX_W-1:0] idx,
			logic signed [pfbu_pkg::COEF_W-1:0] coef);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			samples.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		samples.valid       <= 1'b1;
		samples.command     <= cmd;
		samples.sample_real <= re;
		samples.sample_imag <= im;
		samples.table_index <= idx;
		samples.coeff_value <= coef;
		@(posedge clk);
		while (!samples.ready) @(posedge clk);
		sb.note_input(cmd, re, im, idx, coef);
		items_sent++;
	endtask

	task automatic send_random();
		int pick;
		logic signed [pfbu_pkg::COEF_W-1:0] c;
		logic signed [pfbu_pkg::COEF_W-1:0] gv;
		pick = $urandom_range(0, 99);
		if ($urandom_range(0, 9) == 0) c = 16'($urandom);
		else c = 16'(int'($urandom_range(0, 1023)) - 512);
		if ($urandom_range(0, 3) == 0) gv = 16'($urandom);
		else gv = 16'($urandom_range(64, 768));
		if (pick < 72)
			send_item(pfbu_pkg::CMD_SAMPLE, 4'($urandom), 4'($urandom), 6'($urandom),
				16'($urandom));
		else if (pick < 86)
			send_item(pfbu_pkg::CMD_WEIGHT, 4'($urandom), 4'($urandom),
				6'($urandom_range(0, 63)), c);
		else if (pick < 95)
			send_item(pfbu_pkg::CMD_GAIN, 4'($urandom), 4'($urandom),
				6'($urandom_range(0, 63)), gv);
		else
			send_item(pfbu_pkg::CMD_NONE, 4'($urandom), 4'($urandom), 6'($urandom),
				16'($urandom));
	endtask

	// result side: random stalls, one long hold-off on request
	initial begin
		results.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				results.ready <= 1'b0;
				repeat (3000) @(posedge clk);
				hold_req = 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				results.ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end else begin
				results.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && results.valid && results.ready)
			sb.check_result('{results.out_real, results.out_imag, results.channel,
				results.last});
	end

	initial begin
		int drain;
		sb = new();
		idle_on = 1'b1;
		hold_req = 1'b0;
		items_sent = 0;
		arst_n = 1'b0;
		samples.valid = 1'b0;
		samples.command = pfbu_pkg::CMD_SAMPLE;
		samples.sample_real = '0;
		samples.sample_imag = '0;
		samples.table_index = '0;
		samples.coeff_value = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// table extremes, ignored gain index, unused command, sample extremes
		send_item(pfbu_pkg::CMD_WEIGHT, 4'sd0, 4'sd0, 6'd0, 16'sh7fff);
		send_item(pfbu_pkg::CMD_WEIGHT, 4'sd0, 4'sd0, 6'd63, -16'sh8000);
		send_item(pfbu_pkg::CMD_WEIGHT, 4'sd0, 4'sd0, 6'd31, 16'sd256);
		send_item(pfbu_pkg::CMD_WEIGHT, 4'sd0, 4'sd0, 6'd17, -16'sd300);
		send_item(pfbu_pkg::CMD_GAIN, 4'sd0, 4'sd0, 6'd0, -16'sh8000);
		send_item(pfbu_pkg::CMD_GAIN, 4'sd0, 4'sd0, 6'd15, 16'sh7fff);
		send_item(pfbu_pkg::CMD_GAIN, 4'sd0, 4'sd0, 6'd16, 16'sd1);
		send_item(pfbu_pkg::CMD_GAIN, 4'sd0, 4'sd0, 6'd63, 16'sd0);
		send_item(pfbu_pkg::CMD_GAIN, 4'sd0, 4'sd0, 6'd7, 16'sd0);
		send_item(pfbu_pkg::CMD_NONE, 4'sd7, -4'sd8, 6'd63, 16'shffff);
		send_item(pfbu_pkg::CMD_SAMPLE, -4'sd8, -4'sd8, 6'd63, 16'shffff);
		send_item(pfbu_pkg::CMD_SAMPLE, 4'sd7, 4'sd7, 6'd0, 16'sd0);
		send_item(pfbu_pkg::CMD_SAMPLE, -4'sd8, 4'sd7, 6'd0, 16'sd0);
		send_item(pfbu_pkg::CMD_SAMPLE, 4'sd7, -4'sd8, 6'd0, 16'sd0);

		for (int i = 0; i < 380; i++) begin
			if (i == 160) hold_req = 1'b1;
			if (i == 320) idle_on = 1'b0;
			send_random();
		end
		samples.valid <= 1'b0;

		drain = 0;
		while (sb.pending.size() != 0 && drain < 200000) begin
			@(posedge clk);
			drain++;
		end
		repeat (200) @(posedge clk);

		$display("%0d input beats sent, %0d blocks predicted, %0d result beats checked",
			items_sent, sb.blocks, sb.checked);
		$display("%0d mismatches, %0d results still pending", sb.mismatches,
			sb.pending.size());
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("[pfb_upchannelizer] OK");
		else
			$display("[pfb_upchannelizer] ERROR");
		$finish;
	end
endmodule

### filelist.f
rtl/pfbu_pkg.sv
rtl/pfbu_in_if.sv
rtl/pfbu_out_if.sv
rtl/pfb_upchannelizer.sv
rtl/pfbu_chk.sv
verif/tb_top.sv
